// ===== hdl/mspsg_pkg.sv =====
// Shared types, register codes and fixed constants of the motor speed PID.
// No dependencies; every other file of the block but the checker imports this package.
package mspsg_pkg;

  typedef logic signed [12:0] speed_t;
  typedef logic signed [15:0] steer_t;
  typedef logic        [9:0]  dev_t;
  typedef logic signed [15:0] drive_t;
  typedef logic        [9:0]  duty_t;

  typedef logic [2:0] cfg_idx_t;
  typedef logic [9:0] cfg_data_t;

  localparam cfg_idx_t CFG_PROP_GAIN    = 3'd0;
  localparam cfg_idx_t CFG_DERIV_GAIN   = 3'd1;
  localparam cfg_idx_t CFG_NEG_INT_GAIN = 3'd2;
  localparam cfg_idx_t CFG_VAR_INT_GAIN = 3'd3;
  localparam cfg_idx_t CFG_VAR_INT_BIAS = 3'd4;
  localparam cfg_idx_t CFG_TURN_CUT     = 3'd5;

  // divider modes: plain /10, /20, /80, and /(20 << s) for the sigmoid step
  typedef enum logic [1:0] {
    DM_DIV10,
    DM_DIV20,
    DM_DIV80,
    DM_DIV20_SCALED
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_ctl_t;

  localparam int MUL_W            = 24;
  localparam int DUTY_LIMIT       = 999;
  localparam int CURVE_DEV_LO     = 59;
  localparam int CURVE_DEV_HI     = 77;
  localparam int CURVE_INTEG_MIN  = 100;
  localparam int STALL_SPEED      = 80;
  localparam int STALL_DRIVE      = 900;
  localparam int STALL_TICKS_MAX  = 500;
  localparam int STALL_TICKS_TRIP = 50;

  localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

endpackage

// ===== hdl/mspsg_ifs.sv =====
// Valid/ready channel interfaces: speed sample in, drive word out, config writes.
// Depends on mspsg_pkg.
interface mspsg_in_if;
  import mspsg_pkg::*;
  logic   valid;
  logic   ready;
  speed_t target_speed;
  speed_t measured_speed;
  steer_t steer_error;
  steer_t steer_prev_error;
  dev_t   steer_deviation;
  modport source (output valid, target_speed, measured_speed, steer_error,
                  steer_prev_error, steer_deviation, input ready);
  modport sink (input valid, target_speed, measured_speed, steer_error,
                steer_prev_error, steer_deviation, output ready);
endinterface

interface mspsg_out_if;
  import mspsg_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive_command;
  duty_t  forward_duty;
  duty_t  reverse_duty;
  logic   stalled;
  modport source (output valid, drive_command, forward_duty, reverse_duty, stalled,
                  input ready);
  modport sink (input valid, drive_command, forward_duty, reverse_duty, stalled,
                output ready);
endinterface

interface mspsg_cfg_if;
  import mspsg_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/motor_speed_pid_with_stall_guard.sv =====
// Motor speed PID with variable integral gain, anti-windup, curve cut and stall latch.
// Each word runs the sigmoid index and the integral, derivative and proportional products
// and quotients on the shared bit-serial multiplier (MUL_W steps) and divider (NW steps,
// 42 at the defaults); the sigmoid index and table read are skipped when the error sum is negative.
// One word at a time: a new input is taken only in idle; a finished word may wait in the
// output register. Reset (rst_n low, synchronous): loop state cleared, gains to defaults.
module motor_speed_pid_with_stall_guard #(
  parameter int SIGMOID_ENTRIES = 64,
  parameter int FRAC_BITS       = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  mspsg_cfg_if.sink    cfg_ch,
  mspsg_in_if.sink     in_ch,
  mspsg_out_if.source  out_ch
);
  import mspsg_pkg::*;

  // Datapath width: holds gain * error * 2^FRAC plus 10 * filter state with sign.
  localparam int NW     = (FRAC_BITS + 34 > 41) ? FRAC_BITS + 34 : 41;
  localparam int KW     = $clog2(SIGMOID_ENTRIES);
  localparam int SSHIFT = (16 - FRAC_BITS) & 15;

  localparam logic signed [NW-1:0] S32_MAX = {{(NW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [NW-1:0] S32_MIN = {{(NW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [NW-1:0] S16_MAX = {{(NW-15){1'b0}}, {15{1'b1}}};
  localparam logic signed [NW-1:0] S16_MIN = {{(NW-15){1'b1}}, {15{1'b0}}};
  localparam logic signed [NW-1:0] LIM_Q   = NW'(DUTY_LIMIT * (1 << FRAC_BITS));
  localparam logic signed [NW-1:0] CURVE_Q = NW'(CURVE_INTEG_MIN * (1 << FRAC_BITS));
  localparam logic signed [NW-1:0] RND_Q   = NW'((1 << FRAC_BITS) - 1);

  // Sigmoid table, Q0.16, entry k at x = (k - N/2) * 16 / N, built at elaboration.
  typedef logic [15:0] sig_rom_t [SIGMOID_ENTRIES];

  // elaboration-time long division, shift and subtract
  function automatic longint unsigned cdiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t          rom;
    longint            off;
    longint unsigned   mag, t, whole, f, term, acc, den, num, q;
    longint unsigned   j;
    int                k, i;
    for (k = 0; k < SIGMOID_ENTRIES; k++) begin
      off   = longint'(k) - longint'(SIGMOID_ENTRIES / 2);
      mag   = (off < 0) ? longint'(-off) : longint'(off);
      t     = cdiv(mag * 64'd1048576, 64'(SIGMOID_ENTRIES));
      whole = t >> 16;
      f     = t & 64'hFFFF;
      term  = 64'd1 << 30;
      acc   = term;
      for (i = 1; i <= 12; i++) begin
        term = cdiv(term * f, 64'(i) * 64'd65536);
        if ((i & 1) != 0) acc = acc - term;
        else acc = acc + term;
      end
      for (j = 0; j < whole; j++) begin
        acc = (acc * EXP_M1_Q30 + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + acc;
      num = (off >= 0) ? (64'd1 << 46) : (acc << 16);
      q   = cdiv(num + (den >> 1), den);
      rom[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

  function automatic logic signed [31:0] sat32(input logic signed [NW-1:0] v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // One-hot sequencer: each serial step gets its own state.
  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_KDIV = 13'b0000000000010, // sigmoid index, /80
    ST_KROM = 13'b0000000000100, // table read
    ST_IMUL = 13'b0000000001000, // integral step product
    ST_IDIV = 13'b0000000010000,
    ST_DMUL = 13'b0000000100000, // derivative product
    ST_DDIV = 13'b0000001000000,
    ST_PMUL = 13'b0000010000000, // proportional product
    ST_PDIV = 13'b0000100000000,
    ST_SUM  = 13'b0001000000000, // raw duty
    ST_AW   = 13'b0010000000000, // anti-windup
    ST_CRV  = 13'b0100000000000, // curve cut, drive truncation
    ST_FIN  = 13'b1000000000000  // stall guard, result out
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [9:0] prop_gain_r, deriv_gain_r, turn_cut_r;
  logic [7:0] neg_gain_r, var_gain_r;
  logic [5:0] var_bias_r;

  // loop state
  logic signed [31:0] integ_r, dfilt_r;
  logic signed [13:0] last_r;
  logic [1:0]         cmark_r;
  logic [8:0]         sticks_r;
  logic               slatch_r;

  // per-word working registers
  logic signed [13:0] e_r;
  logic signed [14:0] sum_r, de_r;
  speed_t             meas_r;
  dev_t               dev_r;
  logic               same_sign_r, opp_sign_r;
  logic [15:0]        sig_r;
  logic signed [NW-1:0] step_r, p_r, duty_r, inew_r;
  drive_t             drive_r;
  logic               launched_r;

  // result register
  logic   out_valid_r;
  drive_t out_drive_r;
  duty_t  out_fwd_r, out_rev_r;
  logic   out_stall_r;

  // serial units
  logic                 mul_start, mul_done;
  logic signed [NW-1:0] mul_mcand, mul_prod;
  logic [MUL_W-1:0]     mul_mplier;
  div_ctl_t             div_ctl;
  logic                 div_done;
  logic signed [NW-1:0] div_num, div_quo;

  mspsg_smul #(.PW(NW)) u_smul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  mspsg_sdiv #(.NW(NW), .SHIFT(SSHIFT)) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .done  (div_done),
    .quo   (div_quo)
  );

  // input word decode
  logic signed [13:0] e_in;
  logic signed [16:0] sd_in;
  logic               se_neg, se_pos, sd_neg, sd_pos;

  always_comb begin
    e_in   = 14'(in_ch.target_speed) - 14'(in_ch.measured_speed);
    sd_in  = 17'(in_ch.steer_error) - 17'(in_ch.steer_prev_error);
    se_neg = in_ch.steer_error < 0;
    se_pos = in_ch.steer_error > 0;
    sd_neg = sd_in < 0;
    sd_pos = sd_in > 0;
  end

  // sigmoid index argument: (5 * bias - |e|) * N
  logic [12:0]          abs_e;
  logic signed [15:0]   kx;
  logic signed [NW-1:0] kq;
  logic [KW-1:0]        kidx;
  logic                 sum_pos;

  always_comb begin
    abs_e   = e_r[13] ? 13'(-e_r) : 13'(e_r);
    kx      = 16'(var_bias_r * 5) - 16'(abs_e);
    sum_pos = !sum_r[14];
    kq      = div_quo + NW'(SIGMOID_ENTRIES / 2);
    if (kq < 0) kidx = '0;
    else if (kq > NW'(SIGMOID_ENTRIES - 1)) kidx = KW'(SIGMOID_ENTRIES - 1);
    else kidx = kq[KW-1:0];
  end

  // operand selection for the shared serial units
  always_comb begin
    mul_mcand    = '0;
    mul_mplier   = '0;
    div_ctl.mode = DM_DIV20;
    div_num      = '0;
    unique case (state_r)
      ST_KDIV: begin
        div_ctl.mode = DM_DIV80;
        div_num      = NW'(kx) * NW'(SIGMOID_ENTRIES);
      end
      ST_IMUL: begin
        if (sum_pos) begin
          mul_mcand  = NW'(sum_r);
          mul_mplier = MUL_W'(var_gain_r) * MUL_W'(sig_r);
        end else begin
          mul_mcand  = NW'(sum_r) <<< FRAC_BITS;
          mul_mplier = MUL_W'(neg_gain_r);
        end
      end
      ST_IDIV: begin
        div_ctl.mode = sum_pos ? DM_DIV20_SCALED : DM_DIV20;
        div_num      = mul_prod;
      end
      ST_DMUL: begin
        mul_mcand  = NW'(de_r) <<< FRAC_BITS;
        mul_mplier = MUL_W'(deriv_gain_r);
      end
      ST_DDIV: begin
        div_num = mul_prod + (NW'(dfilt_r) <<< 3) + (NW'(dfilt_r) <<< 1);
      end
      ST_PMUL: begin
        mul_mcand  = NW'(e_r) <<< FRAC_BITS;
        mul_mplier = MUL_W'(prop_gain_r);
      end
      ST_PDIV: begin
        div_ctl.mode = DM_DIV10;
        div_num      = mul_prod;
      end
      default: begin
      end
    endcase
    mul_start = ((state_r == ST_IMUL) || (state_r == ST_DMUL) || (state_r == ST_PMUL))
                && !launched_r;
    div_ctl.start = ((state_r == ST_KDIV) || (state_r == ST_IDIV) ||
                     (state_r == ST_DDIV) || (state_r == ST_PDIV)) && !launched_r;
  end

  // anti-windup: integrate inside the band with the step clipped to the band edge,
  // outside only when the step points back in
  logic signed [NW-1:0] duty_step, aw_integ, aw_duty, integ_w;
  logic                 in_band;

  always_comb begin
    integ_w   = NW'(integ_r);
    duty_step = duty_r + step_r;
    in_band   = (duty_r > -LIM_Q) && (duty_r < LIM_Q);
    aw_integ  = integ_w;
    aw_duty   = duty_r;
    if (in_band) begin
      if (duty_step > LIM_Q) begin
        aw_integ = integ_w + LIM_Q - duty_r;
        aw_duty  = LIM_Q;
      end else if (duty_step < -LIM_Q) begin
        aw_integ = integ_w - LIM_Q - duty_r;
        aw_duty  = -LIM_Q;
      end else begin
        aw_integ = integ_w + step_r;
        aw_duty  = duty_step;
      end
    end else if ((duty_r >= LIM_Q && step_r < 0) || (duty_r <= -LIM_Q && step_r > 0)) begin
      aw_integ = integ_w + step_r;
      aw_duty  = duty_step;
    end
  end

  // curve entry cut and drive truncation toward zero
  logic signed [31:0]   isat;
  logic                 curve_cut;
  logic signed [NW-1:0] trunc_q;
  drive_t               drive_w;

  always_comb begin
    isat      = sat32(inew_r);
    curve_cut = same_sign_r && (dev_r >= dev_t'(CURVE_DEV_LO)) &&
                (dev_r <= dev_t'(CURVE_DEV_HI)) && (NW'(isat) > CURVE_Q) &&
                (cmark_r != 2'd2);
    trunc_q   = duty_r[NW-1] ? ((duty_r + RND_Q) >>> FRAC_BITS) : (duty_r >>> FRAC_BITS);
    if (trunc_q > S16_MAX) drive_w = 16'sh7FFF;
    else if (trunc_q < S16_MIN) drive_w = 16'sh8000;
    else drive_w = trunc_q[15:0];
  end

  // stall guard and duty mapping
  logic        stall_hot, latch_w;
  logic [8:0]  sticks_w;
  logic [16:0] drive_neg;
  duty_t       fwd_w, rev_w;

  always_comb begin
    stall_hot = (meas_r < speed_t'(STALL_SPEED)) && (drive_r > drive_t'(STALL_DRIVE));
    if (!stall_hot) sticks_w = '0;
    else if (sticks_r < 9'(STALL_TICKS_MAX)) sticks_w = sticks_r + 1'b1;
    else sticks_w = sticks_r;
    latch_w   = slatch_r || (sticks_w >= 9'(STALL_TICKS_TRIP));
    drive_neg = 17'(-(17'(drive_r)));
    fwd_w     = '0;
    rev_w     = '0;
    if (!latch_w) begin
      if (!drive_r[15]) begin
        fwd_w = (drive_r > drive_t'(DUTY_LIMIT)) ? duty_t'(DUTY_LIMIT) : drive_r[9:0];
      end else begin
        rev_w = (drive_neg > 17'(DUTY_LIMIT)) ? duty_t'(DUTY_LIMIT) : drive_neg[9:0];
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = (e_in + 15'(last_r) >= 0) ? ST_KDIV : ST_IMUL;
      ST_KDIV: if (div_done) state_nxt = ST_KROM;
      ST_KROM: state_nxt = ST_IMUL;
      ST_IMUL: if (mul_done) state_nxt = ST_IDIV;
      ST_IDIV: if (div_done) state_nxt = ST_DMUL;
      ST_DMUL: if (mul_done) state_nxt = ST_DDIV;
      ST_DDIV: if (div_done) state_nxt = ST_PMUL;
      ST_PMUL: if (mul_done) state_nxt = ST_PDIV;
      ST_PDIV: if (div_done) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_AW;
      ST_AW:   state_nxt = ST_CRV;
      ST_CRV:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      launched_r   <= 1'b0;
      prop_gain_r  <= 10'd180;
      deriv_gain_r <= 10'd10;
      neg_gain_r   <= 8'd11;
      var_gain_r   <= 8'd4;
      var_bias_r   <= 6'd6;
      turn_cut_r   <= 10'd50;
      integ_r      <= '0;
      dfilt_r      <= '0;
      last_r       <= '0;
      cmark_r      <= '0;
      sticks_r     <= '0;
      slatch_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_done || div_done) launched_r <= 1'b0;
      else if (mul_start || div_ctl.start) launched_r <= 1'b1;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_PROP_GAIN:    prop_gain_r  <= cfg_ch.data;
          CFG_DERIV_GAIN:   deriv_gain_r <= cfg_ch.data;
          CFG_NEG_INT_GAIN: neg_gain_r   <= cfg_ch.data[7:0];
          CFG_VAR_INT_GAIN: var_gain_r   <= cfg_ch.data[7:0];
          CFG_VAR_INT_BIAS: var_bias_r   <= cfg_ch.data[5:0];
          CFG_TURN_CUT:     turn_cut_r   <= cfg_ch.data;
          default: ;
        endcase
      end

      if (state_r == ST_DDIV && div_done) dfilt_r <= sat32(div_quo);

      if (state_r == ST_CRV) begin
        if (curve_cut) begin
          integ_r <= sat32(NW'(isat) - (NW'(turn_cut_r) <<< FRAC_BITS));
          cmark_r <= 2'd2;
        end else begin
          integ_r <= isat;
        end
        if (opp_sign_r) cmark_r <= 2'd0;
        last_r <= e_r;
      end

      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_FIN && out_free) begin
        sticks_r    <= sticks_w;
        slatch_r    <= latch_w;
        out_valid_r <= 1'b1;
      end
    end
  end

  // per-word datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      e_r         <= e_in;
      sum_r       <= 15'(e_in) + 15'(last_r);
      de_r        <= 15'(e_in) - 15'(last_r);
      meas_r      <= in_ch.measured_speed;
      dev_r       <= in_ch.steer_deviation;
      same_sign_r <= (sd_neg && se_neg) || (sd_pos && se_pos);
      opp_sign_r  <= (sd_pos && se_neg) || (sd_neg && se_pos);
    end
    if (state_r == ST_KROM) sig_r <= SIG_ROM[kidx];
    if (state_r == ST_IDIV && div_done) step_r <= div_quo;
    if (state_r == ST_PDIV && div_done) p_r <= div_quo;
    if (state_r == ST_SUM) duty_r <= integ_w + p_r + NW'(dfilt_r);
    if (state_r == ST_AW) begin
      inew_r <= aw_integ;
      duty_r <= aw_duty;
    end
    if (state_r == ST_CRV) drive_r <= drive_w;
    if (state_r == ST_FIN && out_free) begin
      out_drive_r <= drive_r;
      out_fwd_r   <= fwd_w;
      out_rev_r   <= rev_w;
      out_stall_r <= latch_w;
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_command = out_drive_r;
  assign out_ch.forward_duty  = out_fwd_r;
  assign out_ch.reverse_duty  = out_rev_r;
  assign out_ch.stalled       = out_stall_r;

endmodule

// ===== hdl/mspsg_smul.sv =====
// Bit-serial shift-add multiplier: unsigned multiplier one bit per cycle.
// Depends on mspsg_pkg (MUL_W).
module mspsg_smul #(
  parameter int PW = 42
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [PW-1:0]        mcand,
  input  logic [mspsg_pkg::MUL_W-1:0] mplier,
  output logic                        done,
  output logic signed [PW-1:0]        prod
);
  import mspsg_pkg::*;

  localparam int CW = $clog2(MUL_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] mc_r;
  logic [MUL_W-1:0]  mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= mcand;
      mp_r  <= mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hdl/mspsg_sdiv.sv =====
// Bit-serial restoring divider by a small constant, rounding half away from zero.
// Depends on mspsg_pkg (div_ctl_t, div_mode_t).
module mspsg_sdiv #(
  parameter int NW    = 42,
  parameter int SHIFT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mspsg_pkg::div_ctl_t   ctl,
  input  logic signed [NW-1:0]  num,
  output logic                  done,
  output logic signed [NW-1:0]  quo
);
  import mspsg_pkg::*;

  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [6:0]    dv_r;
  logic [6:0]    rem_r;
  logic [NW-1:0] a_r;

  logic [NW-1:0] mag;
  logic [NW-1:0] prep;
  logic [6:0]    dv;
  logic [7:0]    trial;
  logic          ge;

  always_comb begin
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    unique case (ctl.mode)
      DM_DIV10: begin
        dv   = 7'd10;
        prep = mag + NW'(5);
      end
      DM_DIV20: begin
        dv   = 7'd20;
        prep = mag + NW'(10);
      end
      DM_DIV80: begin
        dv   = 7'd80;
        prep = mag + NW'(40);
      end
      DM_DIV20_SCALED: begin
        dv   = 7'd20;
        prep = (mag + (NW'(10) << SHIFT)) >> SHIFT;
      end
      default: begin
        dv   = 7'd20;
        prep = mag;
      end
    endcase
    trial = {rem_r, a_r[NW-1]};
    ge    = trial >= {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r <= num[NW-1];
      dv_r  <= dv;
      rem_r <= '0;
      a_r   <= prep;
    end else if (busy_r) begin
      rem_r <= ge ? 7'(trial - {1'b0, dv_r}) : trial[6:0];
      a_r   <= {a_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(a_r) : $signed(a_r);

endmodule

// ===== hdl/mspsg_checker.sv =====
// Port-level checks on the result words of the motor speed PID, bound to the top.
// Depends on motor_speed_pid_with_stall_guard and its channel interfaces.
module mspsg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_drive,
  input logic [9:0]        out_fwd,
  input logic [9:0]        out_rev,
  input logic              out_stalled
);

  // a held word keeps its drive and forward duty
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_fwd))
    else $error("result word changed while stalled");

  a_stall_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stalled |-> out_fwd == 10'd0 && out_rev == 10'd0)
    else $error("duty nonzero with stall latched");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fwd == 10'd0 || out_rev == 10'd0)
    else $error("forward and reverse both driven");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fwd <= 10'd999 && out_rev <= 10'd999)
    else $error("duty above limit");

  a_fwd_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stalled && !out_drive[15] |->
      (out_drive > 16'sd999 && out_fwd == 10'd999) ||
      (out_drive <= 16'sd999 && out_fwd == out_drive[9:0]))
    else $error("forward duty does not follow drive");

endmodule

bind motor_speed_pid_with_stall_guard mspsg_checker u_mspsg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_drive   (out_ch.drive_command),
  .out_fwd     (out_ch.forward_duty),
  .out_rev     (out_ch.reverse_duty),
  .out_stalled (out_ch.stalled)
);
